// ===== sv/ffsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_pkg
// shared types, constants and helpers of the first-fit slot allocator
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int SLOTS_DEF    = 480;
    localparam int BASE_HOUR    = 12;
    localparam int MIN_PER_HOUR = 60;

    localparam logic CMD_BUSY  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [4:0]  busy_start_hour;
        logic [5:0]  busy_start_minute;
        logic [4:0]  busy_end_hour;
        logic [5:0]  busy_end_minute;
        logic [8:0]  task_length;
        logic [15:0] task_number;
    } t_req;

    typedef struct packed {
        logic [15:0] placed_number;
        logic        found;
        logic [4:0]  begin_hour;
        logic [5:0]  begin_minute;
        logic [4:0]  finish_hour;
        logic [5:0]  finish_minute;
    } t_rsp;

    // slot offset from the base hour, minutes above 59 simply add on
    function automatic logic signed [12:0] slot_index(input logic [4:0] hour,
                                                      input logic [5:0] minute);
        logic signed [12:0] h;
        logic signed [12:0] m;
        h = $signed({8'b0, hour}) - 13'(BASE_HOUR);
        m = $signed({7'b0, minute});
        return h * 13'sd60 + m;
    endfunction

endpackage

// ===== sv/ffsa_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_map
// free-slot bitmap memory with a fill pass to all free after reset
// ----------------------------------------------------------------------------
module ffsa_map #(
    parameter int SLOTS = ffsa_pkg::SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clr_en,
    input  logic [$clog2(SLOTS)-1:0] i_clr_addr,
    input  logic                     i_rd_en,
    input  logic [$clog2(SLOTS)-1:0] i_rd_addr,
    output logic                     o_rd_data,
    output logic                     o_ready
);
    import ffsa_pkg::*;

    localparam int AW = $clog2(SLOTS);

    logic          r_mem [SLOTS];
    logic          r_rd_data;
    logic          r_init_busy;
    logic [AW-1:0] r_init_addr;

    // fill pass: one slot per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_busy <= 1'b1;
            r_init_addr <= '0;
        end else if (r_init_busy) begin
            if (r_init_addr == AW'(SLOTS - 1)) begin
                r_init_busy <= 1'b0;
            end
            r_init_addr <= r_init_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n) begin
            if (r_init_busy) begin
                r_mem[r_init_addr] <= 1'b1;
            end else if (i_clr_en) begin
                r_mem[i_clr_addr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_init_busy;

endmodule

// ===== sv/first_fit_slot_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_slot_allocator_top
// first-fit allocator of contiguous one-minute slots after the base hour
// ----------------------------------------------------------------------------
// The block keeps one free bit per minute slot in a single-port-read,
// single-port-write memory with a registered read port. After reset a fill
// pass marks all SLOTS slots free, one per cycle, and the first request is
// taken only when that pass is done. A mark-busy request walks its clipped
// range from start up to but not including end, clears one slot per cycle
// and gives no response. An allocate request scans the map from slot 0, one
// slot per cycle through the memory read port, until the first run of
// task_length free slots ends, then clears that run one slot per cycle; its
// response is loaded into the output register after the clear walk, or after
// the scan on a miss, once that register is free. The start and end
// hour:minute are tracked by counters during the scan and the clear walk.
// Requests are taken one at a time; a finished response sits in an output
// register, so the next request is accepted while it waits.
// ----------------------------------------------------------------------------
module first_fit_slot_allocator_top #(
    parameter int SLOTS = ffsa_pkg::SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  ffsa_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output ffsa_pkg::t_rsp o_rsp
);
    import ffsa_pkg::*;

    localparam int AW  = $clog2(SLOTS);
    localparam int IW  = $clog2(SLOTS + 1);
    localparam int CW  = (IW > 9) ? IW : 9;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_MARK = 3'd2;
    localparam logic [2:0] ST_BUSY = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    // hour:minute step, hour wraps in its 5 bits
    function automatic logic [10:0] hm_inc(input logic [4:0] h, input logic [5:0] m);
        logic [10:0] res;
        if (m == 6'(MIN_PER_HOUR - 1)) begin
            res = {h + 5'd1, 6'd0};
        end else begin
            res = {h, m + 6'd1};
        end
        return res;
    endfunction

    logic [2:0]    r_state, n_state;

    // scan pipeline: read address and the slot whose data is on the read port
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic          r_dv, n_dv;
    logic [IW-1:0] r_chk_idx, n_chk_idx;
    logic [4:0]    r_chk_h, n_chk_h;
    logic [5:0]    r_chk_m, n_chk_m;
    logic [IW-1:0] r_run, n_run;
    logic [IW-1:0] r_rs_idx, n_rs_idx;
    logic [4:0]    r_rs_h, n_rs_h;
    logic [5:0]    r_rs_m, n_rs_m;
    logic [8:0]    r_len, n_len;

    // clear walk
    logic [IW-1:0] r_k, n_k;
    logic [IW-1:0] r_end, n_end;
    logic [8:0]    r_rem, n_rem;
    logic [4:0]    r_cur_h, n_cur_h;
    logic [5:0]    r_cur_m, n_cur_m;

    t_rsp          r_res, n_res;
    t_rsp          r_rsp, n_rsp;
    logic          r_rsp_valid, n_rsp_valid;

    // memory port
    logic          map_ready;
    logic          map_rd_data;
    logic          rd_en;
    logic          clr_en;
    logic [AW-1:0] clr_addr;

    // busy range, clipped to the map
    logic signed [12:0] busy_s_raw, busy_e_raw;
    logic [IW-1:0]      busy_s, busy_e;
    logic [IW-1:0]      run_inc;
    logic               hit;
    logic [10:0]        chk_next, cur_next;

    ffsa_map #(
        .SLOTS (SLOTS)
    ) u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr_en   (clr_en),
        .i_clr_addr (clr_addr),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_rd_idx[AW-1:0]),
        .o_rd_data  (map_rd_data),
        .o_ready    (map_ready)
    );

    assign o_req_ready = (r_state == ST_IDLE) && map_ready;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    always_comb begin
        busy_s_raw = slot_index(i_req.busy_start_hour, i_req.busy_start_minute);
        busy_e_raw = slot_index(i_req.busy_end_hour, i_req.busy_end_minute);
        if (busy_s_raw < 0) begin
            busy_s = '0;
        end else if (busy_s_raw > $signed(13'(SLOTS))) begin
            busy_s = IW'(SLOTS);
        end else begin
            busy_s = busy_s_raw[IW-1:0];
        end
        if (busy_e_raw < 0) begin
            busy_e = '0;
        end else if (busy_e_raw > $signed(13'(SLOTS))) begin
            busy_e = IW'(SLOTS);
        end else begin
            busy_e = busy_e_raw[IW-1:0];
        end
    end

    assign run_inc  = r_run + 1'b1;
    // zero length lands on the first free slot
    assign hit      = map_rd_data && ((r_len == 9'd0) || (CW'(run_inc) >= CW'(r_len)));
    assign chk_next = hm_inc(r_chk_h, r_chk_m);
    assign cur_next = hm_inc(r_cur_h, r_cur_m);

    always_comb begin
        n_state     = r_state;
        n_rd_idx    = r_rd_idx;
        n_dv        = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_chk_h     = r_chk_h;
        n_chk_m     = r_chk_m;
        n_run       = r_run;
        n_rs_idx    = r_rs_idx;
        n_rs_h      = r_rs_h;
        n_rs_m      = r_rs_m;
        n_len       = r_len;
        n_k         = r_k;
        n_end       = r_end;
        n_rem       = r_rem;
        n_cur_h     = r_cur_h;
        n_cur_m     = r_cur_m;
        n_res       = r_res;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid;
        rd_en       = 1'b0;
        clr_en      = 1'b0;
        clr_addr    = r_k[AW-1:0];

        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid && o_req_ready) begin
                    if (i_req.cmd == CMD_BUSY) begin
                        n_k     = busy_s;
                        n_end   = busy_e;
                        n_state = ST_BUSY;
                    end else begin
                        n_rd_idx  = '0;
                        n_chk_idx = '0;
                        n_chk_h   = 5'(BASE_HOUR);
                        n_chk_m   = '0;
                        n_run     = '0;
                        n_len     = i_req.task_length;
                        n_res     = '0;
                        n_res.placed_number = i_req.task_number;
                        n_state   = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                // keep the read port one slot ahead of the check
                if (r_rd_idx < IW'(SLOTS)) begin
                    rd_en    = 1'b1;
                    n_rd_idx = r_rd_idx + 1'b1;
                    n_dv     = 1'b1;
                end
                if (r_dv) begin
                    n_run     = map_rd_data ? run_inc : '0;
                    n_chk_idx = r_chk_idx + 1'b1;
                    {n_chk_h, n_chk_m} = chk_next;
                    if (map_rd_data && (r_run == '0)) begin
                        n_rs_idx = r_chk_idx;
                        n_rs_h   = r_chk_h;
                        n_rs_m   = r_chk_m;
                    end
                    if (hit) begin
                        n_k     = (r_run == '0) ? r_chk_idx : r_rs_idx;
                        n_cur_h = (r_run == '0) ? r_chk_h : r_rs_h;
                        n_cur_m = (r_run == '0) ? r_chk_m : r_rs_m;
                        n_rem   = r_len;
                        n_res.found        = 1'b1;
                        n_res.begin_hour   = n_cur_h;
                        n_res.begin_minute = n_cur_m;
                        n_state = ST_MARK;
                    end else if (r_chk_idx == IW'(SLOTS - 1)) begin
                        // no fitting run, fields stay zero
                        n_state = ST_OUT;
                    end
                end
            end

            ST_MARK: begin
                if (r_rem == 9'd0) begin
                    n_res.finish_hour   = r_cur_h;
                    n_res.finish_minute = r_cur_m;
                    n_state = ST_OUT;
                end else begin
                    clr_en = 1'b1;
                    n_k    = r_k + 1'b1;
                    n_rem  = r_rem - 1'b1;
                    {n_cur_h, n_cur_m} = cur_next;
                end
            end

            ST_BUSY: begin
                if (r_k < r_end) begin
                    clr_en = 1'b1;
                    n_k    = r_k + 1'b1;
                end else begin
                    n_state = ST_IDLE;
                end
            end

            ST_OUT: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_rsp       = r_res;
                    n_rsp_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_dv        <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dv        <= n_dv;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // payload and datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_idx  <= n_rd_idx;
        r_chk_idx <= n_chk_idx;
        r_chk_h   <= n_chk_h;
        r_chk_m   <= n_chk_m;
        r_run     <= n_run;
        r_rs_idx  <= n_rs_idx;
        r_rs_h    <= n_rs_h;
        r_rs_m    <= n_rs_m;
        r_len     <= n_len;
        r_k       <= n_k;
        r_end     <= n_end;
        r_rem     <= n_rem;
        r_cur_h   <= n_cur_h;
        r_cur_m   <= n_cur_m;
        r_res     <= n_res;
        r_rsp     <= n_rsp;
    end

`ifndef SYNTHESIS
    // one request at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("request accepted while busy");

    // slots are cleared only by the walks
    a_clr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_en |-> ((r_state == ST_MARK) || (r_state == ST_BUSY)))
        else $error("slot cleared outside a walk");

    // a run never reaches back before slot 0
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_run <= r_chk_idx))
        else $error("free run longer than scanned slots");

    // a miss carries zero times
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.found) |->
            ((o_rsp.begin_hour == '0) && (o_rsp.finish_hour == '0)))
        else $error("miss response with nonzero time");
`endif

endmodule
